// File: hw/rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg - gradient swatch pixel shared definitions
// Widths, register map, reset values, pipeline split and bundle types.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int MAX_STOPS_DEF  = 4;
  localparam int COORD_BITS_DEF = 12;

  localparam int COLOR_W       = 32;
  localparam int CHAN_W        = 8;
  localparam int COUNT_W       = 3;
  localparam int ROW_W         = 13;
  localparam int TILE_W        = 11;
  localparam int CFG_IDX_W     = 4;
  localparam int NUM_STOP_REGS = 4;

  // pipeline split
  localparam int FRONT_STAGES = 4;
  localparam int LERP_STAGES  = 6;
  localparam int BLEND_STAGES = 2;
  localparam int NUM_STAGES   = FRONT_STAGES + LERP_STAGES + BLEND_STAGES;
  localparam int CHK_FIRST    = 2;
  localparam int CHK_STAGES   = FRONT_STAGES - CHK_FIRST + LERP_STAGES;
  localparam int LDIV_STAGES  = LERP_STAGES - 2;

  localparam logic [CHAN_W-1:0] SHADE_ODD  = 8'd180;
  localparam logic [CHAN_W-1:0] SHADE_EVEN = 8'd220;
  localparam logic [CHAN_W-1:0] BLEND_BIAS = 8'd127;
  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

  localparam logic [COLOR_W-1:0] RESET_STOP       = 32'h0000_00FF;
  localparam logic [COUNT_W-1:0] RESET_STOP_COUNT = 3'd1;
  localparam logic [ROW_W-1:0]   RESET_ROW_WIDTH  = 13'd48;
  localparam logic [TILE_W-1:0]  RESET_TILE_SIZE  = 11'd4;

  typedef logic [CFG_IDX_W-1:0] gsp_cfg_idx_t;

  localparam gsp_cfg_idx_t REG_STOP_0        = 4'd0;
  localparam gsp_cfg_idx_t REG_STOP_1        = 4'd1;
  localparam gsp_cfg_idx_t REG_STOP_2        = 4'd2;
  localparam gsp_cfg_idx_t REG_STOP_3        = 4'd3;
  localparam gsp_cfg_idx_t REG_STOP_COUNT    = 4'd4;
  localparam gsp_cfg_idx_t REG_GRADIENT_MODE = 4'd5;
  localparam gsp_cfg_idx_t REG_ROW_WIDTH     = 4'd6;
  localparam gsp_cfg_idx_t REG_TILE_SIZE     = 4'd7;

  // effective settings, derived from the registers
  typedef struct packed {
    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] s;
    logic               stripe;
    logic               lerp;
    logic [ROW_W-1:0]   w;
    logic [ROW_W-1:0]   d;
    logic [TILE_W-1:0]  t;
  } gsp_cfg_t;

  // selected segment for one beat
  typedef struct packed {
    logic               lerp;
    logic [COLOR_W-1:0] a;
    logic [COLOR_W-1:0] b;
    logic [ROW_W-1:0]   r;
  } gsp_seg_t;

endpackage

// File: hw/rtl/gsp_front.sv
// ----------------------------------------------------------------------------
// gsp_front - input capture, x clamp, segment search and stop selection
// Four stages: capture, clamp and scale, segment compare, stop select.
// ----------------------------------------------------------------------------
module gsp_front #(
  parameter int MAX_STOPS  = gsp_pkg::MAX_STOPS_DEF,
  parameter int COORD_BITS = gsp_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk,
  input  logic [gsp_pkg::FRONT_STAGES-1:0]            en,
  input  logic [COORD_BITS-1:0]                       pos_x,
  input  logic [COORD_BITS-1:0]                       pos_y,
  input  gsp_pkg::gsp_cfg_t                           cfg,
  input  logic [MAX_STOPS-1:0][gsp_pkg::COLOR_W-1:0]  stops,
  output logic [gsp_pkg::ROW_W-1:0]                   xc,
  output logic [COORD_BITS-1:0]                       y,
  output gsp_pkg::gsp_seg_t                           seg
);

  localparam int RW = gsp_pkg::ROW_W;
  localparam int PW = RW + gsp_pkg::COUNT_W;
  localparam int CW = (COORD_BITS > RW) ? COORD_BITS : RW;
  localparam int KB = $clog2(MAX_STOPS);

  logic [COORD_BITS-1:0] x0;
  logic [COORD_BITS-1:0] y0;
  logic [RW-1:0]         xc_next;
  logic [PW-1:0]         p_next;
  logic [PW-1:0]         xn_next;
  logic [PW-1:0]         p1;
  logic [PW-1:0]         xn1;
  logic [KB-1:0]         k_next;
  logic [KB-1:0]         idx_next;
  logic [KB-1:0]         k2;
  logic [KB-1:0]         idx2;
  logic [PW-1:0]         p2;
  logic [KB-1:0]         sel;
  logic [KB-1:0]         k_up;
  gsp_pkg::gsp_seg_t     seg_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0 <= pos_x;
      y0 <= pos_y;
    end
  end

  always_comb begin
    if (CW'(x0) > CW'(cfg.d)) begin
      xc_next = cfg.d;
    end else begin
      xc_next = RW'(x0);
    end
    p_next  = PW'(xc_next) * PW'(cfg.s);
    xn_next = PW'(xc_next) * PW'(cfg.n);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xc  <= xc_next;
      y   <= y0;
      p1  <= p_next;
      xn1 <= xn_next;
    end
  end

  // quotients are below the stop count, so count the multiples passed
  always_comb begin
    k_next   = '0;
    idx_next = '0;
    for (int j = 1; j < MAX_STOPS - 1; j++) begin
      if (j < int'(cfg.s) && (PW'(j) * PW'(cfg.d)) <= p1) begin
        k_next = k_next + 1'b1;
      end
    end
    for (int j = 1; j < MAX_STOPS; j++) begin
      if (j < int'(cfg.n) && (PW'(j) * PW'(cfg.w)) <= xn1) begin
        idx_next = idx_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      k2   <= k_next;
      idx2 <= idx_next;
      p2   <= p1;
    end
  end

  always_comb begin
    sel = '0;
    if (cfg.lerp) begin
      sel = k2;
    end else if (cfg.stripe) begin
      sel = idx2;
    end
    k_up          = k2 + 1'b1;
    seg_next.lerp = cfg.lerp;
    seg_next.a    = stops[sel];
    seg_next.b    = stops[k_up];
    seg_next.r    = RW'(p2 - PW'(k2) * PW'(cfg.d));
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      seg <= seg_next;
    end
  end

endmodule

// File: hw/rtl/gsp_checker.sv
// ----------------------------------------------------------------------------
// gsp_checker - checkerboard parity
// Pipelined restoring division of x and y by the tile edge, a few quotient
// bits per stage; only the parity of the quotient sum leaves.
// ----------------------------------------------------------------------------
module gsp_checker #(
  parameter int COORD_BITS = gsp_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic [gsp_pkg::CHK_STAGES-1:0]   en,
  input  logic [gsp_pkg::ROW_W-1:0]        xc,
  input  logic [COORD_BITS-1:0]            y,
  input  logic [gsp_pkg::TILE_W-1:0]       t,
  output logic                             odd
);

  localparam int NST = gsp_pkg::CHK_STAGES;
  localparam int RW  = gsp_pkg::ROW_W;
  localparam int TW  = gsp_pkg::TILE_W;
  localparam int QB  = (COORD_BITS > RW) ? COORD_BITS : RW;
  localparam int CB  = (QB + NST - 1) / NST;
  localparam int QT  = CB * NST;
  localparam int SW  = TW + QT;

  // {remainder, dividend bits left / quotient bits so far}
  function automatic logic [SW-1:0] div_step(logic [SW-1:0] rq, logic [TW-1:0] dv);
    logic [TW:0]   trial;
    logic [TW-1:0] rem;
    logic [QT-1:0] q;
    rem   = rq[SW-1:QT];
    q     = rq[QT-1:0];
    trial = {rem, q[QT-1]};
    if (trial >= {1'b0, dv}) begin
      rem = TW'(trial - {1'b0, dv});
      q   = {q[QT-2:0], 1'b1};
    end else begin
      rem = trial[TW-1:0];
      q   = {q[QT-2:0], 1'b0};
    end
    return {rem, q};
  endfunction

  logic [SW-1:0] xs  [NST];
  logic [SW-1:0] ys  [NST];
  logic [SW-1:0] xin [NST];
  logic [SW-1:0] yin [NST];
  logic [SW-1:0] xnx [NST];
  logic [SW-1:0] ynx [NST];

  always_comb begin
    xin[0] = {{TW{1'b0}}, QT'(xc)};
    yin[0] = {{TW{1'b0}}, QT'(y)};
    for (int st = 1; st < NST; st++) begin
      xin[st] = xs[st-1];
      yin[st] = ys[st-1];
    end
    for (int st = 0; st < NST; st++) begin
      xnx[st] = xin[st];
      ynx[st] = yin[st];
      for (int i = 0; i < CB; i++) begin
        xnx[st] = div_step(xnx[st], t);
        ynx[st] = div_step(ynx[st], t);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int st = 0; st < NST; st++) begin
      if (en[st]) begin
        xs[st] <= xnx[st];
        ys[st] <= ynx[st];
      end
    end
  end

  assign odd = xs[NST-1][0] ^ ys[NST-1][0];

endmodule

// File: hw/rtl/gsp_lerp.sv
// ----------------------------------------------------------------------------
// gsp_lerp - per-channel interpolation between two stops
// Products, rounded numerator, then a pipelined restoring divider by 2*D
// giving two quotient bits per stage. Non-interpolated beats pass stop a.
// ----------------------------------------------------------------------------
module gsp_lerp (
  input  logic                              clk,
  input  logic [gsp_pkg::LERP_STAGES-1:0]   en,
  input  gsp_pkg::gsp_seg_t                 seg,
  input  logic [gsp_pkg::ROW_W-1:0]         d,
  output logic [gsp_pkg::COLOR_W-1:0]       color
);

  localparam int CHW   = gsp_pkg::CHAN_W;
  localparam int NCH   = gsp_pkg::COLOR_W / gsp_pkg::CHAN_W;
  localparam int RW    = gsp_pkg::ROW_W;
  localparam int PW    = RW + CHW;
  localparam int LW    = RW + 1;
  localparam int NW    = LW + CHW;
  localparam int DS    = gsp_pkg::LDIV_STAGES;
  localparam int STEPS = CHW / DS;
  localparam int LS    = gsp_pkg::LERP_STAGES;

  // {remainder, numerator bits left / quotient bits so far}
  function automatic logic [NW-1:0] div_step(logic [NW-1:0] rq, logic [LW-1:0] dv);
    logic [LW:0]    trial;
    logic [LW-1:0]  rem;
    logic [CHW-1:0] q;
    rem   = rq[NW-1:CHW];
    q     = rq[CHW-1:0];
    trial = {rem, q[CHW-1]};
    if (trial >= {1'b0, dv}) begin
      rem = LW'(trial - {1'b0, dv});
      q   = {q[CHW-2:0], 1'b1};
    end else begin
      rem = trial[LW-1:0];
      q   = {q[CHW-2:0], 1'b0};
    end
    return {rem, q};
  endfunction

  logic [NCH-1:0][PW-1:0]  pa;
  logic [NCH-1:0][PW-1:0]  pb;
  logic [NCH-1:0][NW-1:0]  num;
  logic [NCH-1:0][NW-1:0]  rq  [DS];
  logic [NCH-1:0][NW-1:0]  rin [DS];
  logic [NCH-1:0][NW-1:0]  rnx [DS];
  logic [gsp_pkg::COLOR_W-1:0] base [LS];
  logic [LS-1:0]           lerp;
  logic [LW-1:0]           m;

  assign m = {d, 1'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      base[0] <= seg.a;
      lerp[0] <= seg.lerp;
      for (int c = 0; c < NCH; c++) begin
        pa[c] <= PW'(seg.a[CHW*c +: CHW]) * PW'(d - seg.r);
        pb[c] <= PW'(seg.b[CHW*c +: CHW]) * PW'(seg.r);
      end
    end
    for (int i = 1; i < LS; i++) begin
      if (en[i]) begin
        base[i] <= base[i-1];
        lerp[i] <= lerp[i-1];
      end
    end
    if (en[1]) begin
      for (int c = 0; c < NCH; c++) begin
        num[c] <= ((NW'(pa[c]) + NW'(pb[c])) << 1) + NW'(d);
      end
    end
    for (int st = 0; st < DS; st++) begin
      if (en[st + 2]) begin
        rq[st] <= rnx[st];
      end
    end
  end

  always_comb begin
    rin[0] = num;
    for (int st = 1; st < DS; st++) begin
      rin[st] = rq[st-1];
    end
    for (int st = 0; st < DS; st++) begin
      rnx[st] = rin[st];
      for (int i = 0; i < STEPS; i++) begin
        for (int c = 0; c < NCH; c++) begin
          rnx[st][c] = div_step(rnx[st][c], m);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (lerp[LS-1]) begin
        color[CHW*c +: CHW] = rq[DS-1][c][CHW-1:0];
      end else begin
        color[CHW*c +: CHW] = base[LS-1][CHW*c +: CHW];
      end
    end
  end

endmodule

// File: hw/rtl/gsp_blend.sv
// ----------------------------------------------------------------------------
// gsp_blend - alpha blend over the checkerboard shade
// Stage one forms both products per channel, stage two adds, rounds and
// divides by 255 with the add-and-shift identity into the output register.
// ----------------------------------------------------------------------------
module gsp_blend (
  input  logic                               clk,
  input  logic [gsp_pkg::BLEND_STAGES-1:0]   en,
  input  logic [gsp_pkg::COLOR_W-1:0]        color,
  input  logic                               odd,
  output logic [gsp_pkg::CHAN_W-1:0]         out_red,
  output logic [gsp_pkg::CHAN_W-1:0]         out_green,
  output logic [gsp_pkg::CHAN_W-1:0]         out_blue
);

  localparam int CHW  = gsp_pkg::CHAN_W;
  localparam int CLW  = gsp_pkg::COLOR_W;
  localparam int NOUT = 3;
  localparam int MW   = 2 * CHW;
  localparam int SW   = MW + 1;

  logic [CHW-1:0]           alpha;
  logic [CHW-1:0]           shade;
  logic [NOUT-1:0][MW-1:0]  m_col;
  logic [NOUT-1:0][MW-1:0]  m_bg;
  logic [NOUT-1:0][SW-1:0]  sum;
  logic [NOUT-1:0][SW-1:0]  quo;

  assign alpha = color[CHW-1:0];
  assign shade = odd ? gsp_pkg::SHADE_ODD : gsp_pkg::SHADE_EVEN;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < NOUT; c++) begin
        m_col[c] <= MW'(color[CLW-1-CHW*c -: CHW]) * MW'(alpha);
        m_bg[c]  <= MW'(shade) * MW'(gsp_pkg::CHAN_MAX - alpha);
      end
    end
  end

  // floor(v / 255) = (v + (v >> 8) + 1) >> 8 for v below 65535
  always_comb begin
    for (int c = 0; c < NOUT; c++) begin
      sum[c] = SW'(m_col[c]) + SW'(m_bg[c]) + SW'(gsp_pkg::BLEND_BIAS);
      quo[c] = (sum[c] + (sum[c] >> CHW) + SW'(1)) >> CHW;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out_red   <= quo[0][CHW-1:0];
      out_green <= quo[1][CHW-1:0];
      out_blue  <= quo[2][CHW-1:0];
    end
  end

endmodule

// File: hw/rtl/gradient_swatch_pixel_unit.sv
// ----------------------------------------------------------------------------
// gradient_swatch_pixel_unit - swatch pixel colour over a checkerboard
// Pipeline: 12 register stages, each holding a beat; an accepted beat passes
//   through them in order to the output, and bubbles close.
// Throughput: one pixel per clock while out_stall is low.
// Reset: clears the stage valid bits and loads register defaults; no sweep.
// ----------------------------------------------------------------------------
module gradient_swatch_pixel_unit #(
  parameter int MAX_STOPS  = gsp_pkg::MAX_STOPS_DEF,
  parameter int COORD_BITS = gsp_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COORD_BITS-1:0]           pos_x,
  input  logic [COORD_BITS-1:0]           pos_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gsp_pkg::CHAN_W-1:0]      out_red,
  output logic [gsp_pkg::CHAN_W-1:0]      out_green,
  output logic [gsp_pkg::CHAN_W-1:0]      out_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsp_pkg::COLOR_W-1:0]     cfg_data
);

  localparam int NS  = gsp_pkg::NUM_STAGES;
  localparam int FS  = gsp_pkg::FRONT_STAGES;
  localparam int LS  = gsp_pkg::LERP_STAGES;
  localparam int CF  = gsp_pkg::CHK_FIRST;
  localparam int CNW = gsp_pkg::COUNT_W;
  localparam int RW  = gsp_pkg::ROW_W;
  localparam int TW  = gsp_pkg::TILE_W;

  logic [MAX_STOPS-1:0][gsp_pkg::COLOR_W-1:0] stop_color;
  logic [CNW-1:0]            stop_count;
  logic                      gradient_mode;
  logic [RW-1:0]             row_width;
  logic [TW-1:0]             tile_size;
  gsp_pkg::gsp_cfg_t         cfg;

  logic [NS-1:0]             vld;
  logic [NS-1:0]             en;

  logic [RW-1:0]             xc;
  logic [COORD_BITS-1:0]     y;
  gsp_pkg::gsp_seg_t         seg;
  logic [gsp_pkg::COLOR_W-1:0] color;
  logic                      odd;

  // register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STOPS; i++) begin
        stop_color[i] <= gsp_pkg::RESET_STOP;
      end
      stop_count    <= gsp_pkg::RESET_STOP_COUNT;
      gradient_mode <= 1'b0;
      row_width     <= gsp_pkg::RESET_ROW_WIDTH;
      tile_size     <= gsp_pkg::RESET_TILE_SIZE;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        gsp_pkg::REG_STOP_0, gsp_pkg::REG_STOP_1,
        gsp_pkg::REG_STOP_2, gsp_pkg::REG_STOP_3: begin
          for (int i = 0; i < MAX_STOPS; i++) begin
            if (i < gsp_pkg::NUM_STOP_REGS && cfg_index == gsp_pkg::gsp_cfg_idx_t'(i)) begin
              stop_color[i] <= cfg_data;
            end
          end
        end
        gsp_pkg::REG_STOP_COUNT:    stop_count    <= cfg_data[CNW-1:0];
        gsp_pkg::REG_GRADIENT_MODE: gradient_mode <= cfg_data[0];
        gsp_pkg::REG_ROW_WIDTH:     row_width     <= cfg_data[RW-1:0];
        gsp_pkg::REG_TILE_SIZE:     tile_size     <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg = '0;
    if (stop_count == '0) begin
      cfg.n = CNW'(1);
    end else if (int'(stop_count) > MAX_STOPS) begin
      cfg.n = CNW'(MAX_STOPS);
    end else begin
      cfg.n = stop_count;
    end
    cfg.s      = cfg.n - CNW'(1);
    cfg.w      = (row_width == '0) ? RW'(1) : row_width;
    cfg.d      = cfg.w - RW'(1);
    cfg.t      = (tile_size == '0) ? TW'(1) : tile_size;
    cfg.stripe = (cfg.n > CNW'(1)) && !gradient_mode;
    cfg.lerp   = (cfg.n > CNW'(1)) && gradient_mode && (cfg.d != '0);
  end

  // stage advance: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS-1] = !vld[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NS-1];

  gsp_front #(
    .MAX_STOPS  (MAX_STOPS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk   (clk),
    .en    (en[FS-1:0]),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .cfg   (cfg),
    .stops (stop_color),
    .xc    (xc),
    .y     (y),
    .seg   (seg)
  );

  gsp_checker #(
    .COORD_BITS (COORD_BITS)
  ) u_checker (
    .clk (clk),
    .en  (en[FS+LS-1:CF]),
    .xc  (xc),
    .y   (y),
    .t   (cfg.t),
    .odd (odd)
  );

  gsp_lerp u_lerp (
    .clk   (clk),
    .en    (en[FS+LS-1:FS]),
    .seg   (seg),
    .d     (cfg.d),
    .color (color)
  );

  gsp_blend u_blend (
    .clk       (clk),
    .en        (en[NS-1:FS+LS]),
    .color     (color),
    .odd       (odd),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

// File: bench/gradient_swatch_pixel_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_swatch_pixel_unit_tb - pixel colour checks for the swatch unit
// A short table of directed pixels and register writes, then random settings
// each followed by a burst of random coordinates. Each output beat is checked
// against a table colour or the in-bench predictor; both sides stall randomly.
// ----------------------------------------------------------------------------
module gradient_swatch_pixel_unit_tb;

  localparam int CW            = gsp_pkg::COORD_BITS_DEF;
  localparam int CHW           = gsp_pkg::CHAN_W;
  localparam int CLW           = gsp_pkg::COLOR_W;
  localparam int NSTOP         = gsp_pkg::MAX_STOPS_DEF;
  localparam int ITEMS_PER_SET = 60;
  localparam int SETS_PER_MODE = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int ROW_MAX       = (1 << gsp_pkg::ROW_W) - 1;
  localparam int TILE_MAX      = (1 << gsp_pkg::TILE_W) - 1;
  localparam int COUNT_MAX     = (1 << gsp_pkg::COUNT_W) - 1;
  localparam logic [CW-1:0] X_MAX = '1;

  localparam gsp_pkg::gsp_cfg_idx_t REG_SPARE_FIRST = gsp_pkg::REG_TILE_SIZE + 4'd1;
  localparam gsp_pkg::gsp_cfg_idx_t REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic [CHW-1:0] red;
    logic [CHW-1:0] green;
    logic [CHW-1:0] blue;
  } rgb_t;

  typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_t;
  typedef enum int {SET_RANDOM, SET_HIGH, SET_LOW} setting_t;

  typedef struct packed {
    row_kind_t             kind;
    gsp_pkg::gsp_cfg_idx_t idx;
    logic [CLW-1:0]        data;
    logic [CW-1:0]         x;
    logic [CW-1:0]         y;
    logic                  known;
    rgb_t                  want;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [CW-1:0]         pos_x     = '0;
  logic [CW-1:0]         pos_y     = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHW-1:0]        out_red;
  logic [CHW-1:0]        out_green;
  logic [CHW-1:0]        out_blue;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  gsp_pkg::gsp_cfg_idx_t cfg_index = '0;
  logic [CLW-1:0]        cfg_data  = '0;

  // predictor copy of the register file
  logic [CLW-1:0]               stop_reg [gsp_pkg::NUM_STOP_REGS];
  logic [gsp_pkg::COUNT_W-1:0]  cfg_count = gsp_pkg::RESET_STOP_COUNT;
  logic                         cfg_grad  = 1'b0;
  logic [gsp_pkg::ROW_W-1:0]    cfg_row   = gsp_pkg::RESET_ROW_WIDTH;
  logic [gsp_pkg::TILE_W-1:0]   cfg_tile  = gsp_pkg::RESET_TILE_SIZE;

  rgb_t                 rgb_due_q [$];
  dir_row_t             dir_tab [$];
  int                   send_pct   = 17;
  int                   recv_pct   = 81;
  bit                   hold_req   = 1'b0;
  int                   errors     = 0;
  int                   pixels_in  = 0;
  int                   pixels_out = 0;
  int                   reg_writes = 0;
  int                   settings_run = 0;
  string                chan_name [3] = '{"blue", "green", "red"};
  rgb_t                 due_rgb;
  rgb_t                 got_rgb;
  int                   f;

  always #10 clk = ~clk;

  gradient_swatch_pixel_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    foreach (stop_reg[i]) stop_reg[i] = gsp_pkg::RESET_STOP;
  end

  function automatic logic [CHW-1:0] mix_channel(input int unsigned a, input int unsigned b,
                                                  input int unsigned d, input int unsigned r);
    int unsigned num;
    logic [CHW-1:0] v;
    num = a * (d - r) + b * r;
    v = CHW'((2 * num + d) / (2 * d));
    return v;
  endfunction

  function automatic logic [CHW-1:0] over_checker(input int unsigned c, input int unsigned alpha,
                                                   input int unsigned shade);
    logic [CHW-1:0] v;
    v = CHW'((c * alpha + shade * (255 - alpha) + 127) / 255);
    return v;
  endfunction

  function automatic rgb_t swatch_colour(input logic [CW-1:0] px, input logic [CW-1:0] py);
    int unsigned x, y, w, t, n, d, s, p, k, r, idx;
    int ch;
    logic [CLW-1:0] col, ca, cb;
    logic [CHW-1:0] shade;
    rgb_t res;
    x = px;
    y = py;
    w = (cfg_row == 0) ? 1 : cfg_row;
    t = (cfg_tile == 0) ? 1 : cfg_tile;
    n = cfg_count;
    if (n == 0) n = 1;
    if (n > NSTOP) n = NSTOP;
    if (x > w - 1) x = w - 1;
    col = stop_reg[0];
    if (n > 1) begin
      if (cfg_grad) begin
        d = w - 1;
        if (d > 0) begin
          s = n - 1;
          p = x * s;
          k = p / d;
          if (k > s - 1) k = s - 1;
          r = p - k * d;
          ca = stop_reg[k];
          cb = stop_reg[k + 1];
          for (ch = 0; ch < 4; ch++)
            col[CHW*ch +: CHW] = mix_channel(ca[CHW*ch +: CHW], cb[CHW*ch +: CHW], d, r);
        end
      end else begin
        idx = (x * n) / w;
        if (idx > n - 1) idx = n - 1;
        col = stop_reg[idx];
      end
    end
    shade = (((x / t) + (y / t)) & 1) ? gsp_pkg::SHADE_ODD : gsp_pkg::SHADE_EVEN;
    res.red   = over_checker(col[31:24], col[7:0], shade);
    res.green = over_checker(col[23:16], col[7:0], shade);
    res.blue  = over_checker(col[15:8], col[7:0], shade);
    return res;
  endfunction

  function automatic void tab_reg(input gsp_pkg::gsp_cfg_idx_t idx, input logic [CLW-1:0] data);
    dir_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    dir_tab = {dir_tab, row};
  endfunction

  function automatic void tab_pix(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                  input logic known, input rgb_t want);
    dir_row_t row;
    row = '0;
    row.kind = ROW_PIXEL;
    row.x = x;
    row.y = y;
    row.known = known;
    row.want = want;
    dir_tab = {dir_tab, row};
  endfunction

  task automatic push_pixel(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic known, input rgb_t want);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pos_x <= x;
    pos_y <= y;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    rgb_due_q = {rgb_due_q, (known ? want : swatch_colour(x, y))};
    pixels_in++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (rgb_due_q.size() != 0);
  endtask

  task automatic write_reg(input gsp_pkg::gsp_cfg_idx_t idx, input logic [CLW-1:0] data);
    wait_drained();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    reg_writes++;
    unique case (idx) inside
      gsp_pkg::REG_STOP_0, gsp_pkg::REG_STOP_1,
      gsp_pkg::REG_STOP_2, gsp_pkg::REG_STOP_3: stop_reg[idx[1:0]] = data;
      gsp_pkg::REG_STOP_COUNT:    cfg_count = data[gsp_pkg::COUNT_W-1:0];
      gsp_pkg::REG_GRADIENT_MODE: cfg_grad = data[0];
      gsp_pkg::REG_ROW_WIDTH:     cfg_row = data[gsp_pkg::ROW_W-1:0];
      gsp_pkg::REG_TILE_SIZE:     cfg_tile = data[gsp_pkg::TILE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic pick_settings(input setting_t flav);
    logic [CLW-1:0] colour, junk;
    int unsigned roll, v;
    int i;
    for (i = 0; i < gsp_pkg::NUM_STOP_REGS; i++) begin
      colour = $urandom();
      roll = $urandom_range(3);
      if (roll == 0) colour[7:0] = '0;
      else if (roll == 1) colour[7:0] = '1;
      if (flav == SET_HIGH) colour = '1;
      else if (flav == SET_LOW) colour = '0;
      write_reg(gsp_pkg::gsp_cfg_idx_t'(gsp_pkg::REG_STOP_0 + i), colour);
    end

    junk = $urandom();
    case (flav)
      SET_HIGH: v = COUNT_MAX;
      SET_LOW:  v = 0;
      default:  v = ($urandom_range(9) < 8) ? $urandom_range(1, NSTOP)
                                            : $urandom_range(COUNT_MAX);
    endcase
    colour = junk;
    colour[gsp_pkg::COUNT_W-1:0] = gsp_pkg::COUNT_W'(v);
    write_reg(gsp_pkg::REG_STOP_COUNT, colour);

    junk = $urandom();
    junk[0] = (flav == SET_HIGH) ? 1'b1 : (flav == SET_LOW) ? 1'b0 : 1'($urandom_range(1));
    write_reg(gsp_pkg::REG_GRADIENT_MODE, junk);

    roll = $urandom_range(19);
    if (roll < 10) v = $urandom_range(1, 64);
    else if (roll < 15) v = $urandom_range(65, 4096);
    else if (roll < 18) v = $urandom_range(ROW_MAX);
    else v = (roll == 18) ? 0 : ROW_MAX;
    if (flav == SET_HIGH) v = ROW_MAX;
    else if (flav == SET_LOW) v = 0;
    colour = $urandom();
    colour[gsp_pkg::ROW_W-1:0] = gsp_pkg::ROW_W'(v);
    write_reg(gsp_pkg::REG_ROW_WIDTH, colour);

    roll = $urandom_range(19);
    if (roll < 10) v = $urandom_range(1, 16);
    else if (roll < 15) v = $urandom_range(17, 1024);
    else if (roll < 18) v = $urandom_range(TILE_MAX);
    else v = (roll == 18) ? 0 : TILE_MAX;
    if (flav == SET_HIGH) v = TILE_MAX;
    else if (flav == SET_LOW) v = 0;
    colour = $urandom();
    colour[gsp_pkg::TILE_W-1:0] = gsp_pkg::TILE_W'(v);
    write_reg(gsp_pkg::REG_TILE_SIZE, colour);

    if ($urandom_range(2) == 0)
      write_reg(gsp_pkg::gsp_cfg_idx_t'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                $urandom());
    settings_run++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : recv_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_rgb = {out_red, out_green, out_blue};
      pixels_out++;
      if (rgb_due_q.size() == 0) begin
        $display("%0t: pixel beat with nothing expected, got %0d/%0d/%0d",
                 $time, got_rgb.red, got_rgb.green, got_rgb.blue);
        errors++;
      end else begin
        due_rgb = rgb_due_q.pop_front();
        for (f = 0; f < 3; f++) begin
          if (got_rgb[CHW*f +: CHW] !== due_rgb[CHW*f +: CHW]) begin
            $display("%0t: %s expected %0d got %0d", $time, chan_name[f],
                     due_rgb[CHW*f +: CHW], got_rgb[CHW*f +: CHW]);
            errors++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int m, st, i, xmax;
    int unsigned roll;
    logic [CW-1:0] x, y;
    dir_row_t row;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset colour is opaque black
    tab_pix(0, 0, 1'b1, '0);
    tab_pix(X_MAX, X_MAX, 1'b1, '0);
    tab_reg(gsp_pkg::REG_STOP_0, 32'hFFFF_FFFF);
    tab_pix(0, 0, 1'b1, '1);
    // fully transparent: plain checker shade
    tab_reg(gsp_pkg::REG_STOP_0, 32'h1234_5600);
    tab_pix(0, 0, 1'b1, {3{gsp_pkg::SHADE_EVEN}});
    tab_pix(4, 0, 1'b1, {3{gsp_pkg::SHADE_ODD}});
    tab_reg(gsp_pkg::REG_TILE_SIZE, 32'h0);
    tab_pix(1, 0, 1'b1, {3{gsp_pkg::SHADE_ODD}});
    tab_reg(REG_SPARE_FIRST, 32'hFFFF_FFFF);
    tab_reg(REG_SPARE_LAST, 32'h0);
    tab_pix(1, 1, 1'b1, {3{gsp_pkg::SHADE_EVEN}});
    tab_reg(gsp_pkg::REG_STOP_1, 32'hFF00_0080);
    tab_reg(gsp_pkg::REG_STOP_2, 32'h00FF_00FF);
    tab_reg(gsp_pkg::REG_STOP_3, 32'h0000_FFC0);
    tab_reg(gsp_pkg::REG_STOP_COUNT, 32'd4);
    tab_reg(gsp_pkg::REG_GRADIENT_MODE, 32'd1);
    tab_reg(gsp_pkg::REG_TILE_SIZE, 32'd4);
    tab_pix(0, 0, 1'b0, '0);
    tab_pix(15, 3, 1'b0, '0);
    tab_pix(16, 9, 1'b0, '0);
    tab_pix(47, 47, 1'b0, '0);
    tab_pix(X_MAX, X_MAX, 1'b0, '0);
    tab_reg(gsp_pkg::REG_STOP_COUNT, 32'd7);
    tab_pix(31, 7, 1'b0, '0);
    // single pixel row: gradient collapses to the first stop
    tab_reg(gsp_pkg::REG_ROW_WIDTH, 32'd1);
    tab_pix(X_MAX, 0, 1'b1, {3{gsp_pkg::SHADE_EVEN}});
    tab_reg(gsp_pkg::REG_ROW_WIDTH, 32'd0);
    tab_pix(5, 5, 1'b1, {3{gsp_pkg::SHADE_ODD}});
    tab_reg(gsp_pkg::REG_GRADIENT_MODE, 32'd0);
    tab_reg(gsp_pkg::REG_ROW_WIDTH, 32'd4096);
    tab_reg(gsp_pkg::REG_STOP_COUNT, 32'd0);
    tab_pix(X_MAX, 100, 1'b0, '0);
    tab_reg(gsp_pkg::REG_STOP_COUNT, 32'd5);
    tab_pix(0, 0, 1'b0, '0);
    tab_pix(1023, 0, 1'b0, '0);
    tab_pix(1024, 2, 1'b0, '0);
    tab_pix(X_MAX, X_MAX, 1'b0, '0);
    tab_reg(gsp_pkg::REG_ROW_WIDTH, ROW_MAX);
    tab_reg(gsp_pkg::REG_TILE_SIZE, TILE_MAX);
    tab_pix(X_MAX, 2047, 1'b0, '0);
    tab_pix(X_MAX, 2046, 1'b0, '0);
    tab_reg(gsp_pkg::REG_STOP_COUNT, 32'd2);
    tab_reg(gsp_pkg::REG_GRADIENT_MODE, 32'd1);
    tab_pix(X_MAX, X_MAX, 1'b0, '0);
    tab_reg(gsp_pkg::REG_STOP_COUNT, 32'd3);
    tab_pix(2048, 0, 1'b0, '0);

    foreach (dir_tab[j]) begin
      row = dir_tab[j];
      if (row.kind == ROW_REG) write_reg(row.idx, row.data);
      else push_pixel(row.x, row.y, row.known, row.want);
    end

    for (m = 0; m < 3; m++) begin
      send_pct = (m == 0) ? 17 : (m == 1) ? 81 : 0;
      recv_pct = (m == 0) ? 81 : (m == 1) ? 17 : 0;
      for (st = 0; st < SETS_PER_MODE; st++) begin
        pick_settings((st == 0) ? SET_HIGH : (st == 1) ? SET_LOW : SET_RANDOM);
        if (m == 2 && st == 3) hold_req = 1'b1;
        xmax = (cfg_row == 0) ? 0 : cfg_row - 1;
        if (xmax > X_MAX) xmax = X_MAX;
        for (i = 0; i < ITEMS_PER_SET; i++) begin
          if (m == 0 && st == 4 && i == ITEMS_PER_SET / 2) wait_drained();
          roll = $urandom_range(19);
          if (roll < 14) x = CW'($urandom_range(xmax));
          else if (roll < 17) x = CW'($urandom());
          else if (roll == 17) x = '0;
          else if (roll == 18) x = X_MAX;
          else x = (xmax < X_MAX) ? CW'(xmax + 1) : CW'(xmax);
          roll = $urandom_range(19);
          if (roll < 17) y = CW'($urandom());
          else y = (roll == 17) ? '0 : X_MAX;
          push_pixel(x, y, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (gsp_pkg::NUM_STAGES + 8) @(posedge clk);
    $display("%0d pixels sent, %0d beats checked, %0d register writes over %0d settings",
             pixels_in, pixels_out, reg_writes, settings_run);
    $display("stripe and gradient modes, clamped x, zero width and tile, long output hold");
    if (errors == 0) begin
      $display("gradient_swatch_pixel_unit verification clean");
    end else begin
      $display("gradient_swatch_pixel_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("gradient_swatch_pixel_unit verification failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_front.sv
hw/rtl/gsp_checker.sv
hw/rtl/gsp_lerp.sv
hw/rtl/gsp_blend.sv
hw/rtl/gradient_swatch_pixel_unit.sv
bench/gradient_swatch_pixel_unit_tb.sv
